@@ hw/rtl/shbd_pkg.sv @@
// Package for the set hashed block directory: sizes, operation codes, status codes,
// the bucket hash and the controller/datapath command structs.
// No dependencies.
package shbd_pkg;

    localparam int SETS_DEF    = 16;
    localparam int ASSOC_DEF   = 512;
    localparam int BUCKETS_DEF = 512;

    localparam int FUNC_W   = 3;
    localparam int SET_W    = 4;
    localparam int IDX_W    = 13;
    localparam int TAG_W    = 48;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] F_LOOKUP = 3'd0;
    localparam logic [FUNC_W-1:0] F_HINS   = 3'd1;
    localparam logic [FUNC_W-1:0] F_HREM   = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP    = 3'd3;
    localparam logic [FUNC_W-1:0] F_FINS   = 3'd4;
    localparam logic [FUNC_W-1:0] F_FREM   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] M_NONE = 2'd0;
    localparam logic [1:0] M_FREE = 2'd1;
    localparam logic [1:0] M_HASH = 2'd2;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd4 + 32'h0000feed;

    // Datapath commands that the controller states drive.
    typedef struct packed {
        logic latch;      // capture the input item
        logic rd_way;     // read tag/link/membership of the addressed way
        logic hash;       // recompute the first hash half (with use_tag)
        logic rd_head;    // register the bucket index and start the head read
        logic rd_walk;    // read the way that the walk pointer names
        logic adv_walk;   // advance the walk pointer to the next link
        logic wr_a;       // first write group (self, head)
        logic wr_b;       // second write group (neighbor links)
        logic pop_sel;    // make the free head the working way
        logic rd_pop;     // read the popped way
        logic use_tag;    // hash the stored tag instead of the input block
    } t_cmd;

    typedef struct packed {
        logic [1:0] memb;     // membership of the working way
        logic       head_vld; // head read is a valid link
        logic       walk_vld; // walk pointer valid and budget left
        logic       hit;      // tag of the walked way equals the block
        logic       set_ok;
        logic       idx_ok;
    } t_sts;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        rol32 = (v << s) | (v >> (32 - s));
    endfunction

    // One half of the final mix; the datapath registers it and mix_b finishes the hash.
    function automatic logic [95:0] mix_a(input logic [31:0] w);
        logic [31:0] a, b, c;
        a = w + HASH_INIT;
        b = HASH_INIT;
        c = HASH_INIT;
        c = (c ^ b) - rol32(b, 14);
        a = (a ^ c) - rol32(c, 11);
        b = (b ^ a) - rol32(a, 25);
        c = (c ^ b) - rol32(b, 16);
        mix_a = {a, b, c};
    endfunction

    function automatic logic [31:0] mix_b(input logic [95:0] abc);
        logic [31:0] a, b, c;
        a = abc[95:64];
        b = abc[63:32];
        c = abc[31:0];
        a = (a ^ c) - rol32(c, 4);
        b = (b ^ a) - rol32(a, 14);
        c = (c ^ b) - rol32(b, 24);
        mix_b = c;
    endfunction

endpackage

@@ hw/rtl/shbd_ctrl.sv @@
// Controller for the set hashed block directory: sequences each item.
// Depends on shbd_pkg.
module shbd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [shbd_pkg::FUNC_W-1:0]   i_func,
    input  shbd_pkg::t_sts                i_sts,
    output shbd_pkg::t_cmd                o_cmd,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [shbd_pkg::STATUS_W-1:0] o_status,
    output logic                          o_res_sel
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RWAY  = 4'd1;
    localparam logic [3:0] S_HASHA = 4'd2;
    localparam logic [3:0] S_HASHB = 4'd3;
    localparam logic [3:0] S_HEAD  = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_WRA   = 4'd7;
    localparam logic [3:0] S_WRB   = 4'd8;
    localparam logic [3:0] S_POPR  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_HRD   = 4'd11;

    logic [3:0]                    r_state, n_state;
    logic [shbd_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [shbd_pkg::STATUS_W-1:0] r_stat, n_stat;
    logic                          r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= shbd_pkg::F_LOOKUP;
            r_stat  <= shbd_pkg::ST_OK;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_stat  <= n_stat;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_stat  = r_stat;
        n_res   = r_res;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_func  = i_func;
                    n_state = S_RWAY;
                    n_res   = 1'b0;
                end
            end
            S_RWAY: begin
                o_cmd.rd_way = 1'b1;
                n_state = S_HASHA;
            end
            S_HASHA: begin
                n_state = S_HASHB;
                n_stat  = shbd_pkg::ST_ERR;
                case (r_func) inside
                    shbd_pkg::F_LOOKUP, shbd_pkg::F_POP:
                        if (!i_sts.set_ok) n_state = S_DONE;
                    shbd_pkg::F_HINS, shbd_pkg::F_FINS:
                        if (!i_sts.idx_ok || i_sts.memb != shbd_pkg::M_NONE)
                            n_state = S_DONE;
                    shbd_pkg::F_HREM:
                        if (!i_sts.idx_ok || i_sts.memb != shbd_pkg::M_HASH)
                            n_state = S_DONE;
                    shbd_pkg::F_FREM:
                        if (!i_sts.idx_ok || i_sts.memb != shbd_pkg::M_FREE)
                            n_state = S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_HASHB: begin
                o_cmd.hash    = 1'b1;
                o_cmd.use_tag = (r_func == shbd_pkg::F_HREM);
                n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_stat  = shbd_pkg::ST_OK;
                n_state = S_HRD;
            end
            S_HRD: begin
                // The selected head is being read; it is valid in the next state.
                case (r_func)
                    shbd_pkg::F_LOOKUP: n_state = S_WALK;
                    shbd_pkg::F_POP:    n_state = S_POPR;
                    default:            n_state = S_WRA;
                endcase
            end
            S_POPR: begin
                if (!i_sts.head_vld) begin
                    n_stat  = shbd_pkg::ST_MISS;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop_sel = 1'b1;
                    n_res   = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_func == shbd_pkg::F_POP) begin
                    o_cmd.rd_pop = 1'b1;
                    n_state = S_WRA;
                end else if (!i_sts.walk_vld) begin
                    n_stat  = shbd_pkg::ST_MISS;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_walk = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.adv_walk = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WRA: begin
                o_cmd.wr_a = 1'b1;
                n_state = S_WRB;
            end
            S_WRB: begin
                o_cmd.wr_b = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_status  = r_stat;
    assign o_res_sel = r_res;
endmodule

@@ hw/rtl/shbd_dp.sv @@
// Datapath for the set hashed block directory: tag, link, membership and head memories.
// Depends on shbd_pkg.
module shbd_dp #(
    parameter int SETS    = shbd_pkg::SETS_DEF,
    parameter int ASSOC   = shbd_pkg::ASSOC_DEF,
    parameter int BUCKETS = shbd_pkg::BUCKETS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  shbd_pkg::t_cmd              i_cmd,
    input  logic [shbd_pkg::FUNC_W-1:0] i_func,
    input  logic [shbd_pkg::SET_W-1:0]  i_set_number,
    input  logic [shbd_pkg::IDX_W-1:0]  i_way_index,
    input  logic [shbd_pkg::TAG_W-1:0]  i_block_number,
    output shbd_pkg::t_sts              o_sts,
    output logic [shbd_pkg::IDX_W-1:0]  o_res_index,
    output logic                        o_clearing
);
    localparam int NWAYS = SETS * ASSOC;
    localparam int NBKTS = SETS * BUCKETS;
    localparam int WAY_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;
    localparam int SETI_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int GW    = (NWAYS > 1) ? $clog2(NWAYS) : 1;
    localparam int BK_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BG_W  = (NBKTS > 1) ? $clog2(NBKTS) : 1;
    localparam int L_W   = WAY_W + 1;
    localparam int CW    = ((NWAYS > NBKTS) ? GW : BG_W) + 1;
    localparam int CNT_W = (ASSOC > 1) ? $clog2(ASSOC + 1) : 1;

    logic [shbd_pkg::TAG_W-1:0] m_tag  [NWAYS];
    logic [L_W-1:0]             m_next [NWAYS];
    logic [L_W-1:0]             m_prev [NWAYS];
    logic [1:0]                 m_memb [NWAYS];
    logic [L_W-1:0]             m_bkt  [NBKTS];
    logic [L_W-1:0]             r_fhead [SETS];

    logic [shbd_pkg::FUNC_W-1:0] r_func;
    logic [shbd_pkg::TAG_W-1:0]  r_blk;
    logic [shbd_pkg::TAG_W-1:0]  r_tag;
    logic [L_W-1:0]              r_nx, r_pv, r_head;
    logic [1:0]                  r_memb;
    logic [SETI_W-1:0]           r_set;
    logic [GW-1:0]               r_way;
    logic                        r_set_ok, r_idx_ok;
    logic [95:0]                 r_mix;
    logic [BG_W-1:0]             r_bkt;
    logic [L_W-1:0]              r_walk;
    logic [CNT_W-1:0]            r_steps;
    logic [shbd_pkg::TAG_W-1:0]  r_wtag;
    logic [L_W-1:0]              r_wnext;
    logic [GW-1:0]               r_wway;
    logic [CW-1:0]               r_clr;
    logic                        r_hd_pend;

    logic [31:0]       h_full;
    logic [BK_W-1:0]   h_mod;
    logic [GW-1:0]     base;
    logic [GW-1:0]     walk_g;
    logic [L_W-1:0]    self_l;
    logic              is_hash;

    assign is_hash = (r_func == shbd_pkg::F_HINS) || (r_func == shbd_pkg::F_HREM);
    assign base    = GW'(r_set) * GW'(ASSOC);
    assign walk_g  = base + GW'(r_walk[WAY_W-1:0] % ASSOC);
    assign self_l  = {1'b1, WAY_W'(r_way % ASSOC)};
    assign h_full  = shbd_pkg::mix_b(r_mix);
    assign h_mod   = BK_W'(h_full % BUCKETS);
    assign o_clearing = !r_clr[CW-1];

    // After reset, sweep an index over the entries, clearing links, membership and bucket heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (!r_clr[CW-1]) r_clr <= r_clr + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) r_fhead[s] <= '0;
        end else if (i_cmd.wr_a && !is_hash) begin
            if (r_func == shbd_pkg::F_FINS) r_fhead[r_set] <= self_l;
            else if (!r_pv[WAY_W]) r_fhead[r_set] <= r_nx;
        end
    end

    // The head read happens in the cycle after the bucket index is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hd_pend <= 1'b0;
        else r_hd_pend <= i_cmd.rd_head;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_blk    <= i_block_number;
            r_set_ok <= 32'(i_set_number) < SETS;
            r_idx_ok <= 32'(i_way_index) < NWAYS;
            if (32'(i_set_number) < SETS) r_set <= SETI_W'(i_set_number);
            else r_set <= SETI_W'(32'(i_way_index) / ASSOC);
            r_way    <= GW'(i_way_index);
        end
        if (i_cmd.rd_way) begin
            r_tag  <= m_tag[r_way];
            r_nx   <= m_next[r_way];
            r_pv   <= m_prev[r_way];
            r_memb <= m_memb[r_way];
            r_mix  <= shbd_pkg::mix_a(r_blk[31:0]);
            if (r_func != shbd_pkg::F_LOOKUP && r_func != shbd_pkg::F_POP)
                r_set <= SETI_W'(32'(r_way) / ASSOC);
        end
        if (i_cmd.hash && i_cmd.use_tag) r_mix <= shbd_pkg::mix_a(r_tag[31:0]);
        if (i_cmd.rd_head) begin
            r_bkt   <= BG_W'(r_set) * BG_W'(BUCKETS) + BG_W'(h_mod);
            r_steps <= '0;
        end
        if (r_hd_pend) begin
            if (r_func == shbd_pkg::F_POP || r_func == shbd_pkg::F_FINS
                || r_func == shbd_pkg::F_FREM) begin
                r_head <= r_fhead[r_set];
                r_walk <= r_fhead[r_set];
            end else begin
                r_head <= m_bkt[r_bkt];
                r_walk <= m_bkt[r_bkt];
            end
        end
        if (i_cmd.pop_sel) r_way <= base + GW'(r_head[WAY_W-1:0] % ASSOC);
        if (i_cmd.rd_pop) begin
            r_nx <= m_next[r_way];
            r_pv <= m_prev[r_way];
        end
        if (i_cmd.rd_walk) begin
            r_wtag  <= m_tag[walk_g];
            r_wnext <= m_next[walk_g];
            r_wway  <= walk_g;
        end
        if (i_cmd.adv_walk) begin
            r_walk  <= r_wnext;
            r_steps <= r_steps + CNT_W'(1);
        end
    end

    // Memory writes: the clearing sweep, then the two write groups of an update.
    logic                  ins;
    logic [GW-1:0]         pg, ng, hg;
    assign ins = (r_func == shbd_pkg::F_HINS) || (r_func == shbd_pkg::F_FINS);
    assign pg  = base + GW'(r_pv[WAY_W-1:0] % ASSOC);
    assign ng  = base + GW'(r_nx[WAY_W-1:0] % ASSOC);
    assign hg  = base + GW'(r_head[WAY_W-1:0] % ASSOC);

    always_ff @(posedge i_clk) begin
        if (!r_clr[CW-1]) begin
            if (32'(r_clr) < NWAYS) begin
                m_next[GW'(r_clr)] <= '0;
                m_prev[GW'(r_clr)] <= '0;
                m_memb[GW'(r_clr)] <= shbd_pkg::M_NONE;
            end
            if (32'(r_clr) < NBKTS) m_bkt[BG_W'(r_clr)] <= '0;
        end else if (i_cmd.wr_a) begin
            if (ins) begin
                m_prev[r_way] <= '0;
                m_next[r_way] <= r_head;
                m_memb[r_way] <= is_hash ? shbd_pkg::M_HASH : shbd_pkg::M_FREE;
                if (r_func == shbd_pkg::F_HINS) begin
                    m_tag[r_way] <= r_blk;
                    m_bkt[r_bkt] <= self_l;
                end
            end else begin
                m_prev[r_way] <= '0;
                m_next[r_way] <= '0;
                m_memb[r_way] <= shbd_pkg::M_NONE;
                if (r_pv[WAY_W]) m_next[pg] <= r_nx;
                else if (is_hash) m_bkt[r_bkt] <= r_nx;
            end
        end else if (i_cmd.wr_b) begin
            if (ins) begin
                if (r_head[WAY_W]) m_prev[hg] <= self_l;
            end else if (r_nx[WAY_W]) begin
                m_prev[ng] <= r_pv;
            end
        end
    end

    assign o_sts.memb     = r_memb;
    assign o_sts.head_vld = r_head[WAY_W];
    assign o_sts.walk_vld = r_walk[WAY_W] && (32'(r_steps) < ASSOC);
    assign o_sts.hit      = (r_wtag == r_blk);
    assign o_sts.set_ok   = r_set_ok;
    assign o_sts.idx_ok   = r_idx_ok;
    assign o_res_index    = (r_func == shbd_pkg::F_POP)
                            ? shbd_pkg::IDX_W'(r_way) : shbd_pkg::IDX_W'(r_wway);
endmodule

@@ hw/rtl/set_hashed_block_directory.sv @@
// Set hashed block directory, one item at a time. A lookup walks its bucket chain serially,
// link by link; the next item is taken in the idle state that follows o_done. After reset,
// links, membership and bucket heads are cleared by a sweep over their entries with busy high; the
// receiver cannot stall.
// Depends on shbd_pkg, shbd_ctrl, shbd_dp.
module set_hashed_block_directory #(
    parameter int SETS    = shbd_pkg::SETS_DEF,
    parameter int ASSOC   = shbd_pkg::ASSOC_DEF,
    parameter int BUCKETS = shbd_pkg::BUCKETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [shbd_pkg::FUNC_W-1:0]   i_func,
    input  logic [shbd_pkg::SET_W-1:0]    i_set_number,
    input  logic [shbd_pkg::IDX_W-1:0]    i_way_index,
    input  logic [shbd_pkg::TAG_W-1:0]    i_block_number,
    output logic                          o_done,
    output logic [shbd_pkg::STATUS_W-1:0] o_status,
    output logic [shbd_pkg::IDX_W-1:0]    o_result_index
);
    shbd_pkg::t_cmd              cmd;
    shbd_pkg::t_sts              sts;
    logic                        ctl_busy, clearing, res_sel;
    logic [shbd_pkg::IDX_W-1:0]  res_idx;
    logic [shbd_pkg::STATUS_W-1:0] stat;

    // Hold off new items during the clearing sweep.
    assign busy = ctl_busy || clearing;

    shbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !clearing),
        .i_func   (i_func),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (ctl_busy),
        .o_done   (o_done),
        .o_status (stat),
        .o_res_sel(res_sel)
    );

    shbd_dp #(.SETS(SETS), .ASSOC(ASSOC), .BUCKETS(BUCKETS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_set_number  (i_set_number),
        .i_way_index   (i_way_index),
        .i_block_number(i_block_number),
        .o_sts         (sts),
        .o_res_index   (res_idx),
        .o_clearing    (clearing)
    );

    assign o_status       = stat;
    // Drop the index unless the item found or popped a way.
    assign o_result_index = (res_sel && stat == shbd_pkg::ST_OK) ? res_idx : '0;

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ctl_busy) else $error("done while idle");
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3)) else $error("bad status");
    a_no_clr_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !ctl_busy) else $error("item during clearing");
endmodule

@@ test/tb_set_hashed_block_directory.sv @@
// Testbench for set_hashed_block_directory: directed table, then random directory traffic,
// each result checked against a typed row or a behavioral predictor kept in this file.
// Depends on shbd_pkg and the set_hashed_block_directory RTL.
`timescale 1ns / 100ps

module tb_set_hashed_block_directory;
    import shbd_pkg::*;

    localparam int NSETS  = SETS_DEF;
    localparam int NASSOC = ASSOC_DEF;
    localparam int NBUCK  = BUCKETS_DEF;
    localparam int NWAYS  = NSETS * NASSOC;
    localparam int NHEADS = NSETS * NBUCK;
    localparam logic [10:0] LINK_VLD = 11'h400;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_RANDOM = 1300;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [SET_W-1:0]    i_set_number;
    logic [IDX_W-1:0]    i_way_index;
    logic [TAG_W-1:0]    i_block_number;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_result_index;

    set_hashed_block_directory uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_set_number   (i_set_number),
        .i_way_index    (i_way_index),
        .i_block_number (i_block_number),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_index (o_result_index)
    );

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
    } dir_result_t;

    // Shadow copy of the directory state; links are {valid, way within set}.
    logic [TAG_W-1:0] shadow_tag  [NWAYS];
    logic [10:0]      shadow_next [NWAYS];
    logic [10:0]      shadow_prev [NWAYS];
    logic [1:0]       shadow_memb [NWAYS];
    logic [10:0]      shadow_free [NSETS];
    logic [10:0]      shadow_bkt  [NHEADS];

    dir_result_t pending_results[$];
    int          mismatches;
    int unsigned cycle_count;

    // Recently inserted tags and ways, to make lookups hit and removes succeed.
    logic [TAG_W-1:0] recent_tags[$];
    logic [IDX_W-1:0] recent_ways[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic int bucket_slot(input int set_num, input logic [TAG_W-1:0] blk);
        logic [31:0] seed, a, b, c;
        seed = 32'hdeadbeef + 32'd4 + 32'hfeed;
        a = blk[31:0] + seed;
        b = seed;
        c = seed;
        c = (c ^ b) - rotl(b, 14);
        a = (a ^ c) - rotl(c, 11);
        b = (b ^ a) - rotl(a, 25);
        c = (c ^ b) - rotl(b, 16);
        a = (a ^ c) - rotl(c, 4);
        b = (b ^ a) - rotl(a, 14);
        c = (c ^ b) - rotl(b, 24);
        return set_num * NBUCK + int'(c % NBUCK);
    endfunction

    function automatic int link_way(input int base, input logic [10:0] lnk);
        return base + int'(lnk[9:0]) % NASSOC;
    endfunction

    // Push a way at the head of a list; the head is passed in and returned.
    function automatic logic [10:0] push_way(input int idx, input logic [10:0] head);
        int base;
        base = idx - idx % NASSOC;
        shadow_prev[idx] = '0;
        shadow_next[idx] = head;
        if (head[10])
            shadow_prev[link_way(base, head)] = LINK_VLD | 11'(idx % NASSOC);
        return LINK_VLD | 11'(idx % NASSOC);
    endfunction

    function automatic logic [10:0] unlink_way(input int idx, input logic [10:0] head);
        int base;
        logic [10:0] p, n, h;
        base = idx - idx % NASSOC;
        p = shadow_prev[idx];
        n = shadow_next[idx];
        h = head;
        if (p[10])
            shadow_next[link_way(base, p)] = n;
        else
            h = n;
        if (n[10])
            shadow_prev[link_way(base, n)] = p;
        shadow_prev[idx] = '0;
        shadow_next[idx] = '0;
        shadow_memb[idx] = M_NONE;
        return h;
    endfunction

    function automatic dir_result_t directory_predict(input logic [FUNC_W-1:0] fn,
                                                      input logic [SET_W-1:0] sn,
                                                      input logic [IDX_W-1:0] wi,
                                                      input logic [TAG_W-1:0] blk);
        dir_result_t r;
        int idx, iset, slot, g, steps;
        logic [10:0] lnk;
        r.status = ST_ERR;
        r.index = '0;
        idx = int'(wi);
        iset = idx / NASSOC;
        case (fn)
            F_LOOKUP: begin
                if (int'(sn) < NSETS) begin
                    lnk = shadow_bkt[bucket_slot(int'(sn), blk)];
                    steps = 0;
                    r.status = ST_MISS;
                    while (lnk[10] && steps < NASSOC) begin
                        g = link_way(int'(sn) * NASSOC, lnk);
                        if (shadow_tag[g] == blk) begin
                            r.status = ST_OK;
                            r.index = IDX_W'(g);
                            break;
                        end
                        lnk = shadow_next[g];
                        steps++;
                    end
                end
            end
            F_HINS: begin
                if (idx < NWAYS && shadow_memb[idx] == M_NONE) begin
                    shadow_tag[idx] = blk;
                    slot = bucket_slot(iset, blk);
                    shadow_bkt[slot] = push_way(idx, shadow_bkt[slot]);
                    shadow_memb[idx] = M_HASH;
                    r.status = ST_OK;
                end
            end
            F_HREM: begin
                if (idx < NWAYS && shadow_memb[idx] == M_HASH) begin
                    slot = bucket_slot(iset, shadow_tag[idx]);
                    shadow_bkt[slot] = unlink_way(idx, shadow_bkt[slot]);
                    r.status = ST_OK;
                end
            end
            F_POP: begin
                if (int'(sn) < NSETS) begin
                    lnk = shadow_free[sn];
                    if (lnk[10]) begin
                        g = link_way(int'(sn) * NASSOC, lnk);
                        shadow_free[sn] = unlink_way(g, shadow_free[sn]);
                        r.status = ST_OK;
                        r.index = IDX_W'(g);
                    end else begin
                        r.status = ST_MISS;
                    end
                end
            end
            F_FINS: begin
                if (idx < NWAYS && shadow_memb[idx] == M_NONE) begin
                    shadow_free[iset] = push_way(idx, shadow_free[iset]);
                    shadow_memb[idx] = M_FREE;
                    r.status = ST_OK;
                end
            end
            F_FREM: begin
                if (idx < NWAYS && shadow_memb[idx] == M_FREE) begin
                    shadow_free[iset] = unlink_way(idx, shadow_free[iset]);
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Check every result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        dir_result_t want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d index %0d",
                             o_status, o_result_index);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_result_index !== want.index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d index %0d, got %0d %0d",
                                 want.status, want.index, o_status, o_result_index);
                end
            end
        end
    end

    // Run watchdog: declare failure if the run stalls.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    int sender_idle_pct;

    // Issue one item: hold start until accepted, predict at acceptance.
    // Start stays high on return; the next item or a drain wait takes it over.
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SET_W-1:0] sn,
                             input logic [IDX_W-1:0] wi, input logic [TAG_W-1:0] blk);
        dir_result_t r;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= fn;
        i_set_number   <= sn;
        i_way_index    <= wi;
        i_block_number <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = directory_predict(fn, sn, wi, blk);
        pending_results.push_back(r);
        if (fn == F_HINS && r.status == ST_OK) begin
            recent_tags.push_back(blk);
            recent_ways.push_back(wi);
            if (recent_tags.size() > 64) begin
                void'(recent_tags.pop_front());
                void'(recent_ways.pop_front());
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a way: mostly in two sets and a narrow range so lists get crowded.
    function automatic logic [IDX_W-1:0] pick_way();
        int s;
        s = $urandom_range(99);
        if (s < 70)
            return IDX_W'(($urandom_range(1) * 15) * NASSOC + $urandom_range(23));
        if (s < 85 && recent_ways.size() != 0)
            return recent_ways[$urandom_range(recent_ways.size() - 1)];
        return IDX_W'($urandom());
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int s;
        s = $urandom_range(99);
        if (s < 40 && recent_tags.size() != 0)
            return recent_tags[$urandom_range(recent_tags.size() - 1)];
        if (s < 60)
            return TAG_W'($urandom_range(7)); // few distinct tags, shared buckets
        if (s < 70)
            return {16'($urandom()), 32'($urandom_range(3))}; // low word one of four values
        return {16'($urandom()), 32'($urandom())};
    endfunction

    typedef struct {
        logic [FUNC_W-1:0]   fn;
        logic [SET_W-1:0]    sn;
        logic [IDX_W-1:0]    wi;
        logic [TAG_W-1:0]    blk;
        logic                typed;  // expected result typed in below
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{F_LOOKUP, 4'd0,  13'd0,    48'd0,               1'b1, ST_MISS, 13'd0},
        '{F_POP,    4'd15, 13'd0,    48'd0,               1'b1, ST_MISS, 13'd0},
        '{F_HREM,   4'd0,  13'd5,    48'd0,               1'b1, ST_ERR,  13'd0},
        '{F_FREM,   4'd0,  13'd5,    48'd0,               1'b1, ST_ERR,  13'd0},
        '{3'd6,     4'd0,  13'd0,    48'd0,               1'b1, ST_ERR,  13'd0},
        '{3'd7,     4'd15, 13'd8191, 48'hFFFFFFFFFFFF,    1'b1, ST_ERR,  13'd0},
        '{F_HINS,   4'd0,  13'd8191, 48'hFFFFFFFFFFFF,    1'b1, ST_OK,   13'd0},
        '{F_LOOKUP, 4'd15, 13'd0,    48'hFFFFFFFFFFFF,    1'b1, ST_OK,   13'd8191},
        '{F_HINS,   4'd0,  13'd8191, 48'd1,               1'b1, ST_ERR,  13'd0},
        '{F_FINS,   4'd0,  13'd8191, 48'd0,               1'b1, ST_ERR,  13'd0},
        '{F_HINS,   4'd0,  13'd0,    48'd0,               1'b1, ST_OK,   13'd0},
        '{F_HINS,   4'd0,  13'd1,    48'h1_00000000,      1'b0, ST_OK,   13'd0},
        '{F_LOOKUP, 4'd0,  13'd0,    48'd0,               1'b0, ST_OK,   13'd0},
        '{F_LOOKUP, 4'd0,  13'd0,    48'h1_00000000,      1'b0, ST_OK,   13'd0},
        '{F_HREM,   4'd0,  13'd1,    48'd0,               1'b1, ST_OK,   13'd0},
        '{F_LOOKUP, 4'd0,  13'd0,    48'h1_00000000,      1'b1, ST_MISS, 13'd0},
        '{F_FINS,   4'd0,  13'd1,    48'd0,               1'b1, ST_OK,   13'd0},
        '{F_FINS,   4'd0,  13'd2,    48'd0,               1'b1, ST_OK,   13'd0},
        '{F_FREM,   4'd0,  13'd1,    48'd0,               1'b1, ST_OK,   13'd0},
        '{F_FINS,   4'd0,  13'd2,    48'd0,               1'b1, ST_ERR,  13'd0},
        '{F_POP,    4'd0,  13'd0,    48'd0,               1'b1, ST_OK,   13'd2},
        '{F_POP,    4'd0,  13'd0,    48'd0,               1'b1, ST_MISS, 13'd0},
        '{F_HREM,   4'd0,  13'd8191, 48'd0,               1'b1, ST_OK,   13'd0},
        '{F_HREM,   4'd0,  13'd0,    48'd0,               1'b1, ST_OK,   13'd0}
    };

    initial begin
        int fsel;
        mismatches  = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        foreach (shadow_tag[k]) begin
            shadow_tag[k]  = '0;
            shadow_next[k] = '0;
            shadow_prev[k] = '0;
            shadow_memb[k] = M_NONE;
        end
        foreach (shadow_free[k]) shadow_free[k] = '0;
        foreach (shadow_bkt[k]) shadow_bkt[k] = '0;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = '0;
        i_set_number   = '0;
        i_way_index    = '0;
        i_block_number = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed rows override the prediction, others use it.
        foreach (directed[k]) begin
            send_item(directed[k].fn, directed[k].sn, directed[k].wi, directed[k].blk);
            if (directed[k].typed) begin
                pending_results[$].status = directed[k].status;
                pending_results[$].index  = directed[k].index;
            end
        end
        // Pause the sender until every result is back.
        wait_drained();

        // Random phase: low sender idling, then heavy, then none.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3)
                sender_idle_pct = 56;
            else if (n == 2 * N_RANDOM / 3)
                sender_idle_pct = 0;
            else if (n == 0)
                sender_idle_pct = 6;
            fsel = $urandom_range(99);
            if (fsel < 28)
                send_item(F_HINS, 4'($urandom()), pick_way(), pick_tag());
            else if (fsel < 50)
                send_item(F_LOOKUP, $urandom_range(1) ? 4'd15 : 4'($urandom()),
                          pick_way(), pick_tag());
            else if (fsel < 62)
                send_item(F_HREM, 4'($urandom()), pick_way(), pick_tag());
            else if (fsel < 76)
                send_item(F_FINS, 4'($urandom()), pick_way(), pick_tag());
            else if (fsel < 86)
                send_item(F_FREM, 4'($urandom()), pick_way(), pick_tag());
            else if (fsel < 96)
                send_item(F_POP, $urandom_range(1) ? 4'd15 : 4'($urandom()),
                          pick_way(), pick_tag());
            else
                send_item(3'($urandom_range(7)), 4'($urandom()), 13'($urandom()),
                          {16'($urandom()), 32'($urandom())});
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
